### sv/siphash_keyed_hash_defines.svh
// assertion helpers shared by the rtl, sampled on clk and disabled in reset
`ifndef SIPHASH_KEYED_HASH_DEFINES_SVH
`define SIPHASH_KEYED_HASH_DEFINES_SVH

`define SIPH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define SIPH_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SIPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/siph_pkg.sv
package siph_pkg;

    localparam int C_ROUNDS_DEF = 2;
    localparam int D_ROUNDS_DEF = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

    localparam int VB_W = 4;
    localparam logic [VB_W-1:0] FULL_BYTES = VB_W'(8);

    localparam logic [63:0] INIT0   = 64'h736f6d6570736575;
    localparam logic [63:0] INIT1   = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT2   = 64'h6c7967656e657261;
    localparam logic [63:0] INIT3   = 64'h7465646279746573;
    localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

    typedef logic [3:0][63:0] lanes_t;

    // one classified input item
    typedef struct packed {
        logic [63:0] word;
        logic [63:0] tail;
        logic        start;
        logic        last;
        logic        full_word;
    } blk_t;

endpackage

### sv/siph_front.sv
module siph_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [63:0]                data_word,
    input  logic [siph_pkg::VB_W-1:0]  valid_bytes,
    input  logic                       last,
    output siph_pkg::blk_t             blk
);
    import siph_pkg::*;

    logic            in_msg_reg;
    logic            in_msg_next;
    logic [7:0]      len_reg;
    logic [7:0]      len_next;
    logic [VB_W-1:0] count;
    logic [7:0]      len_sum;
    logic [55:0]     masked;

    always_comb
    begin
        count = (last && (valid_bytes < FULL_BYTES)) ? valid_bytes : FULL_BYTES;
        len_sum = (in_msg_reg ? len_reg : 8'd0) + {4'd0, count};
        for (int i = 0; i < 7; i++)
        begin
            masked[8*i +: 8] = (VB_W'(i) < count) ? data_word[8*i +: 8] : 8'd0;
        end
        blk.word      = data_word;
        // a full last word is absorbed on its own, so its final block holds only the length
        blk.tail      = {len_sum, (count == FULL_BYTES) ? 56'd0 : masked};
        blk.start     = !in_msg_reg;
        blk.last      = last;
        blk.full_word = (count == FULL_BYTES);
        in_msg_next = in_msg_reg;
        len_next    = len_reg;
        if (accept)
        begin
            in_msg_next = !last;
            len_next    = len_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
            len_reg    <= 8'd0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
            len_reg    <= len_next;
        end
    end

endmodule

### sv/siph_queue.sv
`include "siphash_keyed_hash_defines.svh"

module siph_queue #(
    parameter int DEPTH = siph_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  siph_pkg::blk_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output siph_pkg::blk_t rd_data,
    output logic           not_empty
);
    import siph_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blk_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SIPH_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count over depth")
    `SIPH_ASSERT_IMPLIES(a_rd_nonempty, rd_en, count_reg != '0, "read from empty queue")
    `SIPH_ASSERT_NEXT(a_wr_grows, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

### sv/siph_core.sv
`include "siphash_keyed_hash_defines.svh"

module siph_core #(
    parameter int C_ROUNDS = siph_pkg::C_ROUNDS_DEF,
    parameter int D_ROUNDS = siph_pkg::D_ROUNDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    key_low,
    input  logic [63:0]    key_high,
    input  siph_pkg::blk_t head,
    input  logic           head_valid,
    output logic           head_take,
    input  logic           pop,
    output logic           empty,
    output logic [63:0]    hash
);
    import siph_pkg::*;

    localparam int MAX_R = (C_ROUNDS > D_ROUNDS) ? C_ROUNDS : D_ROUNDS;
    localparam int CNT_W = $clog2(MAX_R + 1);

    typedef enum logic [1:0] {IDLE, COMP, FIN} phase_t;

    phase_t           phase_reg, phase_next;
    lanes_t           v_reg, v_next;
    lanes_t           r;
    logic [63:0]      m_reg, m_next;
    logic [63:0]      tail_reg, tail_next;
    logic [63:0]      m_load;
    logic             pend_reg, pend_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]      hash_reg, hash_next;
    logic             out_valid_reg, out_valid_next;
    logic             take;

    function automatic lanes_t sip_round(lanes_t v);
        logic [63:0] a, b, c, d;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b;
        b = {b[50:0], b[63:51]} ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]} ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]} ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]} ^ c;
        c = {c[31:0], c[63:32]};
        return {d, c, b, a};
    endfunction

    assign r         = sip_round(v_reg);
    assign head_take = take;
    assign empty     = !out_valid_reg;
    assign hash      = hash_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        v_next         = v_reg;
        m_next         = m_reg;
        tail_next      = tail_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !pop;
        take           = 1'b0;
        m_load         = head.word;
        case (phase_reg)
            IDLE:
            begin
                take = head_valid;
            end
            COMP:
            begin
                v_next = r;
                if (cnt_reg == CNT_W'(C_ROUNDS - 1))
                begin
                    v_next[0] = r[0] ^ m_reg;
                    if (pend_reg)
                    begin
                        v_next[3] = r[3] ^ tail_reg;
                        m_next    = tail_reg;
                        pend_next = 1'b0;
                        cnt_next  = '0;
                    end
                    else if (last_reg)
                    begin
                        v_next[2]  = r[2] ^ FIN_XOR;
                        phase_next = FIN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = IDLE;
                        take       = head_valid;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FIN:
            begin
                if (cnt_reg == CNT_W'(D_ROUNDS - 1))
                begin
                    if (!out_valid_reg || pop)
                    begin
                        hash_next      = r[0] ^ r[1] ^ r[2] ^ r[3];
                        out_valid_next = 1'b1;
                        phase_next     = IDLE;
                        take           = head_valid;
                    end
                end
                else
                begin
                    v_next   = r;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = IDLE;
            end
        endcase
        if (take)
        begin
            if (head.start)
            begin
                v_next = {INIT3 ^ key_high, INIT2 ^ key_low, INIT1 ^ key_high, INIT0 ^ key_low};
            end
            m_load     = (head.last && !head.full_word) ? head.tail : head.word;
            v_next[3]  = v_next[3] ^ m_load;
            m_next     = m_load;
            pend_next  = head.last && head.full_word;
            last_next  = head.last;
            tail_next  = head.tail;
            cnt_next   = '0;
            phase_next = COMP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= IDLE;
            pend_reg      <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        m_reg    <= m_next;
        tail_reg <= tail_next;
        hash_reg <= hash_next;
    end

    `SIPH_ASSERT_IMPLIES(a_comp_cnt, phase_reg == COMP, cnt_reg < CNT_W'(C_ROUNDS), "compression count out of range")
    `SIPH_ASSERT_IMPLIES(a_fin_cnt, phase_reg == FIN, cnt_reg < CNT_W'(D_ROUNDS), "finalization count out of range")
    `SIPH_ASSERT_IMPLIES(a_pend_last, pend_reg, last_reg && phase_reg == COMP, "tail pending outside last block")

endmodule

### sv/siphash_keyed_hash.sv
// channel  | handshake                  | payload
// input    | push / full                | data_word, valid_bytes, last
// result   | pop / empty                | hash
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// the queue takes one item per cycle until its slots fill; the round unit then
// runs one sipround per cycle while busy: C_ROUNDS siprounds per word, a second
// C_ROUNDS for the length block after a full 8-byte last word, then D_ROUNDS to
// finalize; it takes the next word only when it is through with the current one
// rst_n clears control state and both key registers asynchronously
// a waiting hash stalls the round unit only at the final round; cfg_ready is always high
module siphash_keyed_hash #(
    parameter int C_ROUNDS = siph_pkg::C_ROUNDS_DEF,
    parameter int D_ROUNDS = siph_pkg::D_ROUNDS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [63:0]                     data_word,
    input  logic [siph_pkg::VB_W-1:0]       valid_bytes,
    input  logic                            last,
    output logic                            empty,
    input  logic                            pop,
    output logic [63:0]                     hash,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [siph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                     cfg_data
);
    import siph_pkg::*;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        accept;
    blk_t        front_blk;
    blk_t        head_blk;
    logic        head_valid;
    logic        head_take;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    siph_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .blk         (front_blk)
    );

    siph_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_data   (front_blk),
        .full      (full),
        .rd_en     (head_take),
        .rd_data   (head_blk),
        .not_empty (head_valid)
    );

    siph_core #(
        .C_ROUNDS (C_ROUNDS),
        .D_ROUNDS (D_ROUNDS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .head       (head_blk),
        .head_valid (head_valid),
        .head_take  (head_take),
        .pop        (pop),
        .empty      (empty),
        .hash       (hash)
    );

endmodule
